### hdl/glh_pkg.sv
// Shared types, widths and register codes for the gap-length histogram.
package glh_pkg;

  localparam int WORD_W   = 32;
  localparam int THR_W    = 33;
  localparam int CNT_W    = 15;
  localparam int GAP_W    = 4;
  localparam int BINS_MAX = 11;
  localparam int CFG_IDX_W = 1;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [THR_W-1:0]     thr_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [GAP_W-1:0]     gap_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam count_t COUNT_MAX = '1;

  localparam cfg_idx_t REG_ALPHA = 1'd0;
  localparam cfg_idx_t REG_BETA  = 1'd1;

  localparam thr_t ALPHA_RESET = 33'h0_0000_0000;
  localparam thr_t BETA_RESET  = 33'h0_8000_0000;

  // Histogram snapshot in output layout: slot BINS_MAX-1 is the long-gap bin.
  typedef struct packed {
    count_t [BINS_MAX-1:0] bin;
    count_t                total;
  } hist_snap_t;

  function automatic count_t sat_inc(input count_t c);
    return (c == COUNT_MAX) ? c : count_t'(c + 1'b1);
  endfunction

endpackage

### hdl/glh_if.sv
// Valid/ready channel interfaces for sample words and histogram results.
interface glh_in_if import glh_pkg::*; ;
  logic  valid;
  logic  ready;
  word_t sample_word;
  logic  end_of_stream;

  modport source (output valid, output sample_word, output end_of_stream, input ready);
  modport sink   (input valid, input sample_word, input end_of_stream, output ready);
endinterface

interface glh_out_if import glh_pkg::*; ;
  logic   valid;
  logic   ready;
  count_t gap0_count;
  count_t gap1_count;
  count_t gap2_count;
  count_t gap3_count;
  count_t gap4_count;
  count_t gap5_count;
  count_t gap6_count;
  count_t gap7_count;
  count_t gap8_count;
  count_t gap9_count;
  count_t gap_long_count;
  count_t gaps_total;

  modport source (
    output valid, input ready,
    output gap0_count, output gap1_count, output gap2_count, output gap3_count,
    output gap4_count, output gap5_count, output gap6_count, output gap7_count,
    output gap8_count, output gap9_count, output gap_long_count, output gaps_total
  );
  modport sink (
    input valid, output ready,
    input gap0_count, input gap1_count, input gap2_count, input gap3_count,
    input gap4_count, input gap5_count, input gap6_count, input gap7_count,
    input gap8_count, input gap9_count, input gap_long_count, input gaps_total
  );
endinterface

### hdl/glh_hist.sv
// Hit classification, gap tracking and saturating bin counters.
module glh_hist import glh_pkg::*; #(
  parameter int MAX_ITEMS = 16384,
  parameter int NUM_BINS  = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  word_t      word,
  input  logic       eos,
  input  thr_t       alpha,
  input  thr_t       beta,
  output hist_snap_t snap
);

  localparam int   WS_W     = $clog2(MAX_ITEMS + 1);
  localparam gap_t GAP_LAST = gap_t'(NUM_BINS - 1);

  logic             awaiting_r, awaiting_nxt;
  gap_t             gap_r, gap_nxt;
  count_t           bins_r   [NUM_BINS];
  count_t           bins_nxt [NUM_BINS];
  count_t           total_r, total_nxt;
  logic [WS_W-1:0]  words_r, words_nxt;

  logic live;
  logic hit;
  gap_t sel;

  assign live = (words_r < WS_W'(MAX_ITEMS));
  assign hit  = ({1'b0, word} >= alpha) && ({1'b0, word} < beta);
  assign sel  = (gap_r >= GAP_LAST) ? GAP_LAST : gap_r;

  always_comb begin
    awaiting_nxt = awaiting_r;
    gap_nxt      = gap_r;
    total_nxt    = total_r;
    words_nxt    = words_r;
    for (int b = 0; b < NUM_BINS; b++) begin
      bins_nxt[b] = bins_r[b];
    end
    if (live) begin
      words_nxt = WS_W'(words_r + 1'b1);
      if (hit) begin
        if (!awaiting_r) begin
          for (int b = 0; b < NUM_BINS; b++) begin
            if (sel == gap_t'(b)) begin
              bins_nxt[b] = sat_inc(bins_r[b]);
            end
          end
          total_nxt = sat_inc(total_r);
        end
        awaiting_nxt = 1'b0;
        gap_nxt      = '0;
      end else if (!awaiting_r && (gap_r < GAP_LAST)) begin
        gap_nxt = gap_t'(gap_r + 1'b1);
      end
    end
  end

  // Map into the fixed output layout; unused middle slots read zero.
  for (genvar k = 0; k < BINS_MAX - 1; k++) begin : g_slot
    if (k < NUM_BINS - 1) begin : g_used
      assign snap.bin[k] = bins_nxt[k];
    end else begin : g_zero
      assign snap.bin[k] = '0;
    end
  end
  assign snap.bin[BINS_MAX-1] = bins_nxt[NUM_BINS-1];
  assign snap.total           = total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (en && eos)) begin
      awaiting_r <= 1'b1;
      gap_r      <= '0;
      total_r    <= '0;
      words_r    <= '0;
      for (int b = 0; b < NUM_BINS; b++) begin
        bins_r[b] <= '0;
      end
    end else if (en) begin
      awaiting_r <= awaiting_nxt;
      gap_r      <= gap_nxt;
      total_r    <= total_nxt;
      words_r    <= words_nxt;
      for (int b = 0; b < NUM_BINS; b++) begin
        bins_r[b] <= bins_nxt[b];
      end
    end
  end

endmodule

### hdl/gap_length_histogram_core.sv
// Top level of the gap-length histogram: input register, counters, result register.
//
// The block takes one 32-bit word per transfer and calls it a hit when
// alpha_threshold <= word < beta_threshold (33-bit thresholds, written through
// the cfg_ port: index 0 is alpha, index 1 is beta). After the first hit it
// counts misses and, at every later hit, bumps bin min(gap, NUM_BINS-1) and the
// total; all counters saturate at 32767. Only the first MAX_ITEMS words of a
// stream are examined. The word flagged end_of_stream produces one result
// transfer carrying all eleven bin fields and the total, and the histogram
// state returns to its reset values; the thresholds keep their values.
// Throughput is one word per clock when the input is not stalled: a word lands in the
// input register, and when it advances the compare, the bin update and the total
// update complete while an end of stream loads the result register. The result
// register then presents the result until the output channel takes it.
// The input stalls only when an end-of-stream word finds the result register
// still full and not being drained. Write the thresholds only while no words
// are in flight.
module gap_length_histogram_core import glh_pkg::*; #(
  parameter int MAX_ITEMS = 16384,
  parameter int NUM_BINS  = 11
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  cfg_idx_t  cfg_index,
  input  thr_t      cfg_wdata,
  glh_in_if.sink    in_if,
  glh_out_if.source out_if
);

  // Threshold registers.
  thr_t alpha_r;
  thr_t beta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      beta_r  <= BETA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA: alpha_r <= cfg_wdata;
        REG_BETA:  beta_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: holds one accepted word until it is folded into the counters.
  logic  in_valid_r;
  word_t word_r;
  logic  eos_r;
  logic  advance;
  logic  in_take;
  logic  out_valid_r;

  // A plain word always advances; an end-of-stream word needs room in the
  // result register (empty, or being drained this cycle).
  assign advance = in_valid_r && (!eos_r || !out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_take = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      word_r <= in_if.sample_word;
      eos_r  <= in_if.end_of_stream;
    end
  end

  // Histogram state and the snapshot including the current word.
  hist_snap_t snap;

  glh_hist #(
    .MAX_ITEMS (MAX_ITEMS),
    .NUM_BINS  (NUM_BINS)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .word  (word_r),
    .eos   (eos_r),
    .alpha (alpha_r),
    .beta  (beta_r),
    .snap  (snap)
  );

  // Result register: load on end of stream, drop valid once the transfer completes.
  hist_snap_t res_r;
  logic       load_res;

  assign load_res = advance && eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_res) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_r <= snap;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.gap0_count     = res_r.bin[0];
  assign out_if.gap1_count     = res_r.bin[1];
  assign out_if.gap2_count     = res_r.bin[2];
  assign out_if.gap3_count     = res_r.bin[3];
  assign out_if.gap4_count     = res_r.bin[4];
  assign out_if.gap5_count     = res_r.bin[5];
  assign out_if.gap6_count     = res_r.bin[6];
  assign out_if.gap7_count     = res_r.bin[7];
  assign out_if.gap8_count     = res_r.bin[8];
  assign out_if.gap9_count     = res_r.bin[9];
  assign out_if.gap_long_count = res_r.bin[BINS_MAX-1];
  assign out_if.gaps_total     = res_r.total;

endmodule

### bench/testbench.sv
// Self-checking testbench for the gap-length histogram core.
module testbench import glh_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS   = 16384;
  localparam int NUM_BINS    = 11;
  localparam int COUNT_CAP   = 32767;
  localparam int CYCLE_LIMIT = 300000;
  // Extra wait at the end of settling, after every result has come back.
  localparam int SETTLE_CYCLES = 4;
  // Window of cycles in which neither side idles.
  localparam int STEADY_FROM = 300;
  localparam int STEADY_TO   = 900;
  localparam int IDLE_PCT    = 21;
  localparam thr_t THR_TOP   = 33'h1_0000_0000;

  typedef struct {
    word_t word;
    logic  last;
  } sample_t;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  thr_t     cfg_wdata;

  glh_in_if  in_ch ();
  glh_out_if out_ch ();

  gap_length_histogram_core #(
    .MAX_ITEMS (MAX_ITEMS),
    .NUM_BINS  (NUM_BINS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Words waiting to be driven, and histograms the block still owes us.
  sample_t    word_queue[$];
  hist_snap_t pending_hists[$];

  int cycle_count = 0;
  int fail_count  = 0;

  // Shadow of the block: thresholds and histogram state.
  thr_t lo_thr        = ALPHA_RESET;
  thr_t hi_thr        = BETA_RESET;
  bit   waiting_first = 1'b1;
  int   gap_run       = 0;
  int   bin_tally[BINS_MAX];
  int   gap_sum       = 0;
  int   words_seen    = 0;

  string field_tag[BINS_MAX + 1] = '{
    "gap0_count", "gap1_count", "gap2_count", "gap3_count", "gap4_count",
    "gap5_count", "gap6_count", "gap7_count", "gap8_count", "gap9_count",
    "gap_long_count", "gaps_total"
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Steady window: no idling on either side.
  function automatic bit steady();
    return (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);
  endfunction

  function automatic int bump(input int v);
    return (v < COUNT_CAP) ? v + 1 : COUNT_CAP;
  endfunction

  task automatic clear_tally();
    waiting_first = 1'b1;
    gap_run       = 0;
    gap_sum       = 0;
    words_seen    = 0;
    foreach (bin_tally[k]) bin_tally[k] = 0;
  endtask

  // Advance the shadow histogram by one accepted word; queue a snapshot on end of stream.
  task automatic tally_word(input word_t w, input logic last);
    bit         hit;
    int         slot;
    hist_snap_t snap;
    if (words_seen < MAX_ITEMS) begin
      hit = (thr_t'(w) >= lo_thr) && (thr_t'(w) < hi_thr);
      words_seen++;
      if (hit) begin
        if (!waiting_first) begin
          slot = (gap_run >= NUM_BINS - 1) ? NUM_BINS - 1 : gap_run;
          bin_tally[slot] = bump(bin_tally[slot]);
          gap_sum = bump(gap_sum);
        end
        waiting_first = 1'b0;
        gap_run = 0;
      end else if (!waiting_first && gap_run < NUM_BINS - 1) begin
        gap_run++;
      end
    end
    if (last) begin
      for (int k = 0; k < BINS_MAX - 1; k++)
        snap.bin[k] = (k < NUM_BINS - 1) ? count_t'(bin_tally[k]) : '0;
      snap.bin[BINS_MAX-1] = count_t'(bin_tally[NUM_BINS-1]);
      snap.total = count_t'(gap_sum);
      pending_hists.push_back(snap);
      clear_tally();
    end
  endtask

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic check_hist(input hist_snap_t got);
    hist_snap_t want;
    if (pending_hists.size() == 0) begin
      note_fail($sformatf("unexpected result transfer at cycle %0d", cycle_count));
      return;
    end
    want = pending_hists.pop_front();
    for (int k = 0; k < BINS_MAX; k++)
      if (got.bin[k] !== want.bin[k])
        note_fail($sformatf("%s: expected %0d, got %0d", field_tag[k], want.bin[k],
                            got.bin[k]));
    if (got.total !== want.total)
      note_fail($sformatf("%s: expected %0d, got %0d", field_tag[BINS_MAX], want.total,
                          got.total));
  endtask

  // Cycle count and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Driver: account for the transfer that just happened, then present the next word
  // or idle. A word already on the bus is held until it is taken.
  always @(posedge clk) begin
    sample_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        tally_word(in_ch.sample_word, in_ch.end_of_stream);
      if (!in_ch.valid || in_ch.ready) begin
        if (word_queue.size() > 0 && (steady() || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = word_queue.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.sample_word   <= nxt.word;
          in_ch.end_of_stream <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, and stall the result side at random.
  always @(posedge clk) begin
    hist_snap_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.bin[0]  = out_ch.gap0_count;
        got.bin[1]  = out_ch.gap1_count;
        got.bin[2]  = out_ch.gap2_count;
        got.bin[3]  = out_ch.gap3_count;
        got.bin[4]  = out_ch.gap4_count;
        got.bin[5]  = out_ch.gap5_count;
        got.bin[6]  = out_ch.gap6_count;
        got.bin[7]  = out_ch.gap7_count;
        got.bin[8]  = out_ch.gap8_count;
        got.bin[9]  = out_ch.gap9_count;
        got.bin[10] = out_ch.gap_long_count;
        got.total   = out_ch.gaps_total;
        check_hist(got);
      end
      out_ch.ready <= steady() || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_word(input word_t w, input logic last);
    sample_t s;
    s.word = w;
    s.last = last;
    word_queue.push_back(s);
  endtask

  // Hold until every word is taken and every histogram has come back, then let the
  // pipeline drain. Sampled on the falling edge, clear of the clocked blocks.
  task automatic settle();
    do @(negedge clk);
    while (word_queue.size() != 0 || in_ch.valid || pending_hists.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Program both thresholds; only called while the block is idle.
  task automatic set_window(input thr_t alpha, input thr_t beta);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ALPHA;
    cfg_wdata <= alpha;
    @(posedge clk);
    cfg_index <= REG_BETA;
    cfg_wdata <= beta;
    @(posedge clk);
    cfg_we <= 1'b0;
    lo_thr = alpha;
    hi_thr = beta;
    @(negedge clk);
  endtask

  // Pick a word that should hit or miss the current window. Now and then take a
  // word on one of the window edges, or a plain random word.
  function automatic word_t pick_word(input bit want_hit);
    int roll;
    bit hit_ok;
    bit below_ok;
    bit above_ok;
    roll     = $urandom_range(99);
    hit_ok   = lo_thr < hi_thr;
    below_ok = lo_thr != 0;
    above_ok = !hi_thr[32];
    if (roll < 8) return $urandom;
    if (roll < 14) begin
      case ($urandom_range(3))
        0:       return word_t'(lo_thr);
        1:       return word_t'(lo_thr - 1);
        2:       return word_t'(hi_thr - 1);
        default: return word_t'(hi_thr);
      endcase
    end
    if (want_hit && hit_ok)
      return $urandom_range(word_t'(hi_thr - 1), word_t'(lo_thr));
    if (!hit_ok) return $urandom;
    if (below_ok && (!above_ok || $urandom_range(1)))
      return $urandom_range(word_t'(lo_thr - 1), 0);
    if (above_ok) return $urandom_range(32'hFFFF_FFFF, word_t'(hi_thr));
    return $urandom;
  endfunction

  // Queue random streams totalling n words; the last word of each stream closes it.
  task automatic random_streams(input int n);
    int done;
    int len;
    int hit_pct;
    done = 0;
    while (done < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(80, 25) : $urandom_range(24, 1);
      if (len > n - done) len = n - done;
      case ($urandom_range(3))
        0:       hit_pct = 50;
        1:       hit_pct = 25;
        2:       hit_pct = 10;
        default: hit_pct = 90;
      endcase
      for (int i = 0; i < len; i++)
        push_word(pick_word($urandom_range(99) < hit_pct), i == len - 1);
      done += len;
    end
  endtask

  // Random non-empty window [alpha, beta) with beta up to 2^32.
  task automatic random_window();
    thr_t alpha;
    thr_t span;
    alpha = $urandom;
    span  = THR_TOP - alpha - 1;
    set_window(alpha, alpha + 1 + $urandom_range(word_t'(span), 0));
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_ALPHA;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.sample_word   = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready        = 1'b0;
    clear_tally();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed streams at the reset window [0, 2^31).
    push_word(32'hFFFF_FFFF, 1'b1);  // stream of one miss: all zeros
    push_word(32'h0000_0000, 1'b0);  // first hit, opens counting
    push_word(32'h7FFF_FFFF, 1'b0);  // gap of zero, top of window
    push_word(32'h8000_0000, 1'b0);  // miss right at the upper bound
    push_word(32'h1234_5678, 1'b0);  // gap of one
    for (int i = 0; i < 12; i++)     // run past the long-gap saturation
      push_word((i % 2) ? 32'hAAAA_AAAA : 32'hFFFF_FFFF, 1'b0);
    push_word(32'h5555_5555, 1'b0);  // long gap
    push_word(32'hAAAA_AAAA, 1'b0);
    push_word(32'hDEAD_BEEF, 1'b0);
    push_word(32'h7FFF_FFFF, 1'b0);  // gap of two
    push_word(32'h0000_0001, 1'b1);  // gap of zero closing the stream
    push_word(32'h0000_0000, 1'b1);  // lone hit: no gap completes
    settle();

    // Whole range hits.
    set_window(33'h0, THR_TOP);
    random_streams(100);
    settle();

    random_window();
    random_streams(130);
    settle();

    // Empty windows: both bounds at the top, alpha above beta, both at zero.
    set_window(THR_TOP, THR_TOP);
    random_streams(60);
    settle();
    set_window(33'h0_C000_0000, 33'h0_4000_0000);
    random_streams(60);
    settle();
    set_window(33'h0, 33'h0);
    random_streams(40);
    settle();

    // Narrow window at the top of the range, then nearly everything.
    set_window(33'h0_FFFF_FFF0, THR_TOP);
    random_streams(130);
    settle();
    set_window(33'h0_0000_0001, 33'h0_FFFF_FFFF);
    random_streams(130);
    settle();

    random_window();
    random_streams(100);
    settle();
    random_window();
    random_streams(100);
    settle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### gap_length_histogram_core.f
hdl/glh_pkg.sv
hdl/glh_if.sv
hdl/glh_hist.sv
hdl/gap_length_histogram_core.sv
bench/testbench.sv
